// ----- hw/rtl/lpm_pkg.sv -----
package lpm_pkg;

    // Coordinate format of the pixel ports
    localparam int COORD_FRAC_BITS = 4;

    // Field widths
    localparam int PIX_W      = 16;
    localparam int OUT_W      = 18;
    localparam int FOCAL_W    = 24;
    localparam int CENTRE_W   = 20;
    localparam int COEF_W     = 32;
    localparam int TAN_W      = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    // Internal fixed point: signed, 24 fraction bits
    localparam int QFRAC = 24;

    // Pixel to Q.8 alignment and the matching output rounding shift
    localparam int PIX_SH     = 8 - COORD_FRAC_BITS;
    localparam int PIX8_W     = PIX_W + PIX_SH;
    localparam int MAG_W      = (PIX8_W > CENTRE_W) ? PIX8_W : CENTRE_W;
    localparam int DVD_W      = MAG_W + QFRAC + 1;
    localparam int DIV_N      = DVD_W;
    localparam int ROUND_HALF = (2 ** PIX_SH) / 2;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [OUT_W-1:0]  dist_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
    typedef logic signed [63:0]       qval_t;

    typedef struct packed {
        logic  sat;
        qval_t val;
    } qsum_t;

    localparam qval_t QMAX    = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam qval_t Q_ONE   = 64'sh0000_0000_0100_0000;
    localparam qval_t OUT_MAX = 64'sd131071;
    localparam qval_t OUT_MIN = -64'sd131072;

    localparam logic [FOCAL_W-1:0] FOCAL_MIN = 24'd256;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTRE_X,
        REG_CENTRE_Y,
        REG_RADIAL_K1,
        REG_RADIAL_K2,
        REG_RADIAL_K3,
        REG_TANGENTIAL
    } cfg_reg_e;

    // Saturating add, clipped to +-QMAX
    function automatic qsum_t q_sadd(qval_t a, qval_t b);
        logic signed [64:0] s;
        qsum_t r;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, QMAX})) begin
            r.sat = 1'b1;
            r.val = QMAX;
        end
        else if (s < -$signed({1'b0, QMAX})) begin
            r.sat = 1'b1;
            r.val = -QMAX;
        end
        else begin
            r.sat = 1'b0;
            r.val = s[63:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/lpm_if.sv -----
// Pixel coordinate channel
interface lpm_pix_if;
    import lpm_pkg::*;
    logic valid;
    logic ready;
    pix_t pixel_x;
    pix_t pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// Distorted coordinate channel
interface lpm_dist_if;
    import lpm_pkg::*;
    logic  valid;
    logic  ready;
    dist_t dist_x;
    dist_t dist_y;
    logic  saturated;
    modport source (output valid, output dist_x, output dist_y, output saturated, input ready);
    modport sink (input valid, input dist_x, input dist_y, input saturated, output ready);
endinterface

// Register write channel
interface lpm_cfg_if;
    import lpm_pkg::*;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lpm_qmul.sv -----
// Q.24 x Q.24 multiply, rounded half away from zero, saturating at +-QMAX.
// Four register stages: magnitude, partial products, sum, clip and sign.
module lpm_qmul (
    input  logic          clk,
    input  logic          en,
    input  lpm_pkg::qval_t a,
    input  lpm_pkg::qval_t b,
    output lpm_pkg::qval_t p,
    output logic          sat
);
    import lpm_pkg::*;

    localparam logic [124:0] ROUND_Q = 125'd1 << (QFRAC - 1);

    logic [63:0]  na_next, nb_next;
    logic [61:0]  ua_next, ub_next;
    logic [61:0]  ua_reg, ub_reg;
    logic         neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]  pll_next, pll_reg;
    logic [61:0]  plh_next, plh_reg;
    logic [61:0]  phl_next, phl_reg;
    logic [59:0]  phh_next, phh_reg;
    logic [124:0] sum_next, sum_reg;
    logic         ovf_next;
    logic [61:0]  mag_next;
    qval_t        p_next, p_reg;
    logic         sat_reg;

    // Stage 1: magnitudes
    always_comb
    begin
        na_next = -a;
        nb_next = -b;
        ua_next = a[63] ? na_next[61:0] : a[61:0];
        ub_next = b[63] ? nb_next[61:0] : b[61:0];
    end

    // Stage 2: 32-bit partial products
    always_comb
    begin
        pll_next = ua_reg[31:0] * ub_reg[31:0];
        plh_next = ua_reg[31:0] * ub_reg[61:32];
        phl_next = ua_reg[61:32] * ub_reg[31:0];
        phh_next = ua_reg[61:32] * ub_reg[61:32];
    end

    // Stage 3: full product plus rounding half
    always_comb
    begin
        sum_next = 125'(pll_reg) + (125'(plh_reg) << 32) + (125'(phl_reg) << 32)
                 + (125'(phh_reg) << 64) + ROUND_Q;
    end

    // Stage 4: drop fraction, clip, restore sign
    always_comb
    begin
        ovf_next = |sum_reg[124:86];
        mag_next = ovf_next ? QMAX[61:0] : sum_reg[85:24];
        p_next   = neg3_reg ? -qval_t'({2'b00, mag_next}) : qval_t'({2'b00, mag_next});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= ua_next;
            ub_reg   <= ub_next;
            neg1_reg <= a[63] ^ b[63];
            pll_reg  <= pll_next;
            plh_reg  <= plh_next;
            phl_reg  <= phl_next;
            phh_reg  <= phh_next;
            neg2_reg <= neg1_reg;
            sum_reg  <= sum_next;
            neg3_reg <= neg2_reg;
            p_reg    <= p_next;
            sat_reg  <= ovf_next;
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;

endmodule

// ----- hw/rtl/lens_distortion_point_map.sv -----
// Lens distortion point map (five-coefficient radial and tangential model).
// pix: one pixel coordinate pair per transfer, Q12.4 unsigned.
// dout: one distorted pair per input, Q14.4 signed, with a flag set when any
//   intermediate value or an output coordinate was clipped.
// cfg: register writes (focal lengths, centre, k1..k3, packed p1/p2), always
//   ready; write only while no item is in flight. Unknown indexes are dropped.
// Throughput: one item per clock unless the output stalls. The pipeline has 1 + DIV_N + 32
//   register stages, 78 with four coordinate fraction bits. The normalizing divide is a
//   restoring divider with one quotient bit per stage (DIV_N stages), followed by a
//   32-stage chain of multipliers and saturating adders.
// The whole pipeline moves as one: it advances while the output stage is
//   empty or being taken, so pix.ready follows dout.ready when the output is
//   full and stays high while it is empty. A stall holds every stage.
// Reset clears the stage valid bits and returns the registers to focal 1.0,
//   centre 0 and zero coefficients.
module lens_distortion_point_map (
    input  logic              clk,
    input  logic              rst_n,
    lpm_pix_if.sink           pix,
    lpm_dist_if.source        dout,
    lpm_cfg_if.sink           cfg
);
    import lpm_pkg::*;

    localparam int VLD_N = DIV_N + 1 + 32;

    // Configuration registers (index 0 = x axis, 1 = y axis)
    logic [FOCAL_W-1:0]  focal_reg  [2];
    logic [CENTRE_W-1:0] centre_reg [2];
    logic [COEF_W-1:0]   k1_reg, k2_reg, k3_reg;
    logic [CFG_DATA_W-1:0] tan_reg;

    logic [FOCAL_W-1:0] focal_eff [2];
    qval_t k1, k2, k3, p1, p2;
    qval_t focal_q [2];
    qval_t centre_q [2];

    logic en;
    logic [VLD_N-1:0] valid_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg[0]  <= FOCAL_MIN;
            focal_reg[1]  <= FOCAL_MIN;
            centre_reg[0] <= '0;
            centre_reg[1] <= '0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            k3_reg        <= '0;
            tan_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FOCAL_X:    focal_reg[0]  <= cfg.data[FOCAL_W-1:0];
                REG_FOCAL_Y:    focal_reg[1]  <= cfg.data[FOCAL_W-1:0];
                REG_CENTRE_X:   centre_reg[0] <= cfg.data[CENTRE_W-1:0];
                REG_CENTRE_Y:   centre_reg[1] <= cfg.data[CENTRE_W-1:0];
                REG_RADIAL_K1:  k1_reg        <= cfg.data[COEF_W-1:0];
                REG_RADIAL_K2:  k2_reg        <= cfg.data[COEF_W-1:0];
                REG_RADIAL_K3:  k3_reg        <= cfg.data[COEF_W-1:0];
                REG_TANGENTIAL: tan_reg       <= cfg.data;
                default: ;
            endcase
        end
    end

    // Coefficients widened to Q.24; focal below 1.0 acts as 1.0
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            focal_eff[a] = (focal_reg[a] < FOCAL_MIN) ? FOCAL_MIN : focal_reg[a];
            focal_q[a]   = $signed(64'(focal_eff[a]));
            centre_q[a]  = $signed(64'(centre_reg[a]));
        end
        k1 = qval_t'($signed(k1_reg));
        k2 = qval_t'($signed(k2_reg));
        k3 = qval_t'($signed(k3_reg));
        p1 = qval_t'($signed(tan_reg[TAN_W-1:0])) <<< 4;
        p2 = qval_t'($signed(tan_reg[2*TAN_W-1:TAN_W])) <<< 4;
    end

    // Global advance: output empty or being taken
    assign en        = !valid_reg[VLD_N-1] || dout.ready;
    assign pix.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[VLD_N-2:0], pix.valid};
    end

    // ---------------------------------------------------------------
    // Normalization: (pixel - centre) / focal, restoring divider
    // Stage 0 forms the dividend, stages 1..DIV_N make one bit each
    // ---------------------------------------------------------------
    logic [23:0]      dv_rem_reg  [DIV_N+1][2];
    logic [DVD_W-1:0] dv_dvd_reg  [DIV_N+1][2];
    logic [DVD_W-1:0] dv_q_reg    [DIV_N+1][2];
    logic             dv_neg_reg  [DIV_N+1][2];
    logic [23:0]      dv_rem_next [DIV_N+1][2];
    logic [DVD_W-1:0] dv_dvd_next [DIV_N+1][2];
    logic [DVD_W-1:0] dv_q_next   [DIV_N+1][2];
    logic             dv_neg_next [DIV_N+1][2];

    always_comb
    begin
        logic [PIX_W-1:0]      pv;
        logic [PIX8_W-1:0]     pix8;
        logic signed [MAG_W:0] diff;
        logic [MAG_W:0]        ndiff;
        logic [MAG_W-1:0]      mag;
        logic [24:0]           trial;
        logic [24:0]           dsr;
        logic                  ge;
        for (int a = 0; a < 2; a++)
        begin
            pv    = (a == 0) ? pix.pixel_x : pix.pixel_y;
            pix8  = PIX8_W'(pv) << PIX_SH;
            diff  = $signed({1'b0, MAG_W'(pix8)}) - $signed({1'b0, MAG_W'(centre_reg[a])});
            ndiff = -diff;
            mag   = diff[MAG_W] ? ndiff[MAG_W-1:0] : diff[MAG_W-1:0];
            dv_rem_next[0][a] = '0;
            dv_q_next[0][a]   = '0;
            dv_neg_next[0][a] = diff[MAG_W];
            dv_dvd_next[0][a] = {1'b0, mag, {QFRAC{1'b0}}} + DVD_W'(focal_eff[a] >> 1);
        end
        for (int k = 1; k <= DIV_N; k++)
        begin
            for (int a = 0; a < 2; a++)
            begin
                trial = {dv_rem_reg[k-1][a], dv_dvd_reg[k-1][a][DVD_W-1]};
                dsr   = {1'b0, focal_eff[a]};
                ge    = (trial >= dsr);
                dv_rem_next[k][a] = ge ? 24'(trial - dsr) : trial[23:0];
                dv_dvd_next[k][a] = dv_dvd_reg[k-1][a] << 1;
                dv_q_next[k][a]   = {dv_q_reg[k-1][a][DVD_W-2:0], ge};
                dv_neg_next[k][a] = dv_neg_reg[k-1][a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_N; k++)
            begin
                for (int a = 0; a < 2; a++)
                begin
                    dv_rem_reg[k][a] <= dv_rem_next[k][a];
                    dv_dvd_reg[k][a] <= dv_dvd_next[k][a];
                    dv_q_reg[k][a]   <= dv_q_next[k][a];
                    dv_neg_reg[k][a] <= dv_neg_next[k][a];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Distortion polynomial, stages A0..A31 after the divider
    // ---------------------------------------------------------------
    qval_t s0_x_reg [2];
    qval_t x_dly_reg [18][2];

    qval_t xx, yy, xy, r4, k1r2, p1xy, p2xy, p2ax, p1ay, r6, k2r4, k3r6;
    qval_t xrad, yrad, xf, yf;
    logic  xx_sat, yy_sat, xy_sat, r4_sat, k1r2_sat, p1xy_sat, p2xy_sat, p2ax_sat;
    logic  p1ay_sat, r6_sat, k2r4_sat, k3r6_sat, xrad_sat, yrad_sat, xf_sat, yf_sat;

    qval_t s5_r2_reg, s5_xx2_reg, s5_yy2_reg, s5_xy_reg;
    qval_t r2_dly_reg [4];
    qval_t s6_ax_reg, s6_ay_reg;
    qval_t s10_rad1_reg, s10_tx_reg, s10_ty_reg;
    qval_t rad1_dly_reg [3];
    qval_t tx_dly_reg [12];
    qval_t p1ay_dly_reg [12];
    qval_t p2ax_dly_reg [13];
    qval_t ty_dly_reg [13];
    qval_t s14_rad2_reg;
    qval_t rad2_dly_reg [3];
    qval_t s18_rad_reg;
    qval_t s23_xd1_reg, s23_yd1_reg;
    qval_t s24_xd_reg, s24_yd_reg;
    qval_t s29_tx_reg, s29_ty_reg;
    qval_t s30_rx_reg, s30_ry_reg;
    dist_t s31_x_reg, s31_y_reg;

    qsum_t s5_r2, s5_xx2, s5_yy2, s6_ax, s6_ay, s10_rad1, s10_tx, s10_ty;
    qsum_t s14_rad2, s18_rad, s23_xd1, s23_yd1, s24_xd, s24_yd, s29_tx, s29_ty;
    qval_t s30_rx, s30_ry;
    dist_t s31_x, s31_y;
    logic  s31_sat;

    logic [31:0] sat_reg;
    logic [31:0] sat_add;
    logic [31:0] sat_mul;
    logic [31:0] sat_eff;

    // Multipliers, named by the product they form
    lpm_qmul u_xx   (.clk(clk), .en(en), .a(s0_x_reg[0]), .b(s0_x_reg[0]), .p(xx), .sat(xx_sat));
    lpm_qmul u_yy   (.clk(clk), .en(en), .a(s0_x_reg[1]), .b(s0_x_reg[1]), .p(yy), .sat(yy_sat));
    lpm_qmul u_xy   (.clk(clk), .en(en), .a(s0_x_reg[0]), .b(s0_x_reg[1]), .p(xy), .sat(xy_sat));
    lpm_qmul u_r4   (.clk(clk), .en(en), .a(s5_r2_reg), .b(s5_r2_reg), .p(r4), .sat(r4_sat));
    lpm_qmul u_k1r2 (.clk(clk), .en(en), .a(k1), .b(s5_r2_reg), .p(k1r2), .sat(k1r2_sat));
    lpm_qmul u_p1xy (.clk(clk), .en(en), .a(p1), .b(s5_xy_reg), .p(p1xy), .sat(p1xy_sat));
    lpm_qmul u_p2xy (.clk(clk), .en(en), .a(p2), .b(s5_xy_reg), .p(p2xy), .sat(p2xy_sat));
    lpm_qmul u_p2ax (.clk(clk), .en(en), .a(p2), .b(s6_ax_reg), .p(p2ax), .sat(p2ax_sat));
    lpm_qmul u_p1ay (.clk(clk), .en(en), .a(p1), .b(s6_ay_reg), .p(p1ay), .sat(p1ay_sat));
    lpm_qmul u_r6   (.clk(clk), .en(en), .a(r4), .b(r2_dly_reg[3]), .p(r6), .sat(r6_sat));
    lpm_qmul u_k2r4 (.clk(clk), .en(en), .a(k2), .b(r4), .p(k2r4), .sat(k2r4_sat));
    lpm_qmul u_k3r6 (.clk(clk), .en(en), .a(k3), .b(r6), .p(k3r6), .sat(k3r6_sat));
    lpm_qmul u_xrad (.clk(clk), .en(en), .a(x_dly_reg[17][0]), .b(s18_rad_reg),
                     .p(xrad), .sat(xrad_sat));
    lpm_qmul u_yrad (.clk(clk), .en(en), .a(x_dly_reg[17][1]), .b(s18_rad_reg),
                     .p(yrad), .sat(yrad_sat));
    lpm_qmul u_xf   (.clk(clk), .en(en), .a(s24_xd_reg), .b(focal_q[0]), .p(xf), .sat(xf_sat));
    lpm_qmul u_yf   (.clk(clk), .en(en), .a(s24_yd_reg), .b(focal_q[1]), .p(yf), .sat(yf_sat));

    // Saturating sums, rounding back to pixels and output clip
    always_comb
    begin
        logic [63:0] tm, tmr;
        s5_r2    = q_sadd(xx, yy);
        s5_xx2   = q_sadd(xx, xx);
        s5_yy2   = q_sadd(yy, yy);
        s6_ax    = q_sadd(s5_r2_reg, s5_xx2_reg);
        s6_ay    = q_sadd(s5_r2_reg, s5_yy2_reg);
        s10_rad1 = q_sadd(Q_ONE, k1r2);
        s10_tx   = q_sadd(p1xy, p1xy);
        s10_ty   = q_sadd(p2xy, p2xy);
        s14_rad2 = q_sadd(rad1_dly_reg[2], k2r4);
        s18_rad  = q_sadd(rad2_dly_reg[2], k3r6);
        s23_xd1  = q_sadd(xrad, tx_dly_reg[11]);
        s23_yd1  = q_sadd(yrad, p1ay_dly_reg[11]);
        s24_xd   = q_sadd(s23_xd1_reg, p2ax_dly_reg[12]);
        s24_yd   = q_sadd(s23_yd1_reg, ty_dly_reg[12]);
        s29_tx   = q_sadd(xf, centre_q[0]);
        s29_ty   = q_sadd(yf, centre_q[1]);

        // Round half away from zero to the coordinate fraction
        tm     = s29_tx_reg[63] ? 64'(-s29_tx_reg) : 64'(s29_tx_reg);
        tmr    = (tm + 64'(ROUND_HALF)) >> PIX_SH;
        s30_rx = s29_tx_reg[63] ? -$signed(tmr) : $signed(tmr);
        tm     = s29_ty_reg[63] ? 64'(-s29_ty_reg) : 64'(s29_ty_reg);
        tmr    = (tm + 64'(ROUND_HALF)) >> PIX_SH;
        s30_ry = s29_ty_reg[63] ? -$signed(tmr) : $signed(tmr);

        // Clip to the output range
        s31_sat = 1'b0;
        if (s30_rx_reg > OUT_MAX)
        begin
            s31_x   = OUT_W'(OUT_MAX);
            s31_sat = 1'b1;
        end
        else if (s30_rx_reg < OUT_MIN)
        begin
            s31_x   = OUT_W'(OUT_MIN);
            s31_sat = 1'b1;
        end
        else
            s31_x = OUT_W'(s30_rx_reg);
        if (s30_ry_reg > OUT_MAX)
        begin
            s31_y   = OUT_W'(OUT_MAX);
            s31_sat = 1'b1;
        end
        else if (s30_ry_reg < OUT_MIN)
        begin
            s31_y   = OUT_W'(OUT_MIN);
            s31_sat = 1'b1;
        end
        else
            s31_y = OUT_W'(s30_ry_reg);
    end

    // Clip flags by the stage they appear in
    always_comb
    begin
        sat_add     = '0;
        sat_mul     = '0;
        sat_mul[4]  = xx_sat | yy_sat | xy_sat;
        sat_add[5]  = s5_r2.sat | s5_xx2.sat | s5_yy2.sat;
        sat_add[6]  = s6_ax.sat | s6_ay.sat;
        sat_mul[9]  = r4_sat | k1r2_sat | p1xy_sat | p2xy_sat;
        sat_mul[10] = p2ax_sat | p1ay_sat;
        sat_add[10] = s10_rad1.sat | s10_tx.sat | s10_ty.sat;
        sat_mul[13] = r6_sat | k2r4_sat;
        sat_add[14] = s14_rad2.sat;
        sat_mul[17] = k3r6_sat;
        sat_add[18] = s18_rad.sat;
        sat_mul[22] = xrad_sat | yrad_sat;
        sat_add[23] = s23_xd1.sat | s23_yd1.sat;
        sat_add[24] = s24_xd.sat | s24_yd.sat;
        sat_mul[28] = xf_sat | yf_sat;
        sat_add[29] = s29_tx.sat | s29_ty.sat;
        sat_add[31] = s31_sat;
        sat_eff     = sat_reg | sat_mul;
    end

    // Stage registers and delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 2; a++)
            begin
                s0_x_reg[a] <= dv_neg_reg[DIV_N][a] ? -qval_t'(dv_q_reg[DIV_N][a])
                                                    : qval_t'(dv_q_reg[DIV_N][a]);
                x_dly_reg[0][a] <= s0_x_reg[a];
                for (int i = 1; i < 18; i++)
                    x_dly_reg[i][a] <= x_dly_reg[i-1][a];
            end

            s5_r2_reg  <= s5_r2.val;
            s5_xx2_reg <= s5_xx2.val;
            s5_yy2_reg <= s5_yy2.val;
            s5_xy_reg  <= xy;
            r2_dly_reg[0] <= s5_r2_reg;
            for (int i = 1; i < 4; i++)
                r2_dly_reg[i] <= r2_dly_reg[i-1];

            s6_ax_reg <= s6_ax.val;
            s6_ay_reg <= s6_ay.val;

            s10_rad1_reg <= s10_rad1.val;
            s10_tx_reg   <= s10_tx.val;
            s10_ty_reg   <= s10_ty.val;
            rad1_dly_reg[0] <= s10_rad1_reg;
            for (int i = 1; i < 3; i++)
                rad1_dly_reg[i] <= rad1_dly_reg[i-1];
            tx_dly_reg[0]   <= s10_tx_reg;
            p1ay_dly_reg[0] <= p1ay;
            for (int i = 1; i < 12; i++)
            begin
                tx_dly_reg[i]   <= tx_dly_reg[i-1];
                p1ay_dly_reg[i] <= p1ay_dly_reg[i-1];
            end
            p2ax_dly_reg[0] <= p2ax;
            ty_dly_reg[0]   <= s10_ty_reg;
            for (int i = 1; i < 13; i++)
            begin
                p2ax_dly_reg[i] <= p2ax_dly_reg[i-1];
                ty_dly_reg[i]   <= ty_dly_reg[i-1];
            end

            s14_rad2_reg <= s14_rad2.val;
            rad2_dly_reg[0] <= s14_rad2_reg;
            for (int i = 1; i < 3; i++)
                rad2_dly_reg[i] <= rad2_dly_reg[i-1];
            s18_rad_reg <= s18_rad.val;

            s23_xd1_reg <= s23_xd1.val;
            s23_yd1_reg <= s23_yd1.val;
            s24_xd_reg  <= s24_xd.val;
            s24_yd_reg  <= s24_yd.val;
            s29_tx_reg  <= s29_tx.val;
            s29_ty_reg  <= s29_ty.val;
            s30_rx_reg  <= s30_rx;
            s30_ry_reg  <= s30_ry;
            s31_x_reg   <= s31_x;
            s31_y_reg   <= s31_y;

            // Clip flag travels with the item
            sat_reg[0] <= 1'b0;
            for (int k = 1; k < 32; k++)
                sat_reg[k] <= sat_eff[k-1] | sat_add[k];
        end
    end

    // Output stage
    assign dout.valid     = valid_reg[VLD_N-1];
    assign dout.dist_x    = s31_x_reg;
    assign dout.dist_y    = s31_y_reg;
    assign dout.saturated = sat_reg[31];

endmodule

// ----- hw/rtl/lpm_checker.sv -----
// Port-level checks for the point map
module lpm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pix_valid,
    input logic           pix_ready,
    input logic           dist_valid,
    input logic           dist_ready,
    input lpm_pkg::dist_t dist_x,
    input lpm_pkg::dist_t dist_y,
    input logic           saturated,
    input logic           cfg_ready
);

    // A result held by the sink stays put
    a_dist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid && !dist_ready |=> dist_valid && $stable(dist_x) && $stable(dist_y)
                                      && $stable(saturated))
        else $error("result changed while stalled");

    // Empty output never blocks the input side
    a_empty_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !dist_valid |-> pix_ready)
        else $error("input blocked with empty output");

    // Sink ready lets the whole pipeline advance
    a_sink_flow: assert property (@(posedge clk) disable iff (!rst_n)
        dist_ready |-> pix_ready)
        else $error("input blocked while sink ready");

    // Register port never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid || !pix_valid |-> cfg_ready)
        else $error("register port not ready");

endmodule

bind lens_distortion_point_map lpm_checker u_lpm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix.valid),
    .pix_ready  (pix.ready),
    .dist_valid (dout.valid),
    .dist_ready (dout.ready),
    .dist_x     (dout.dist_x),
    .dist_y     (dout.dist_y),
    .saturated  (dout.saturated),
    .cfg_ready  (cfg.ready)
);

// ----- tb/tb_ifs.sv -----
`timescale 1ns / 1ps
// Testbench copies of the channel interfaces are not needed; the RTL interfaces are used.
// This file holds the shared transfer record types of the testbench.
package tb_lpm_types;
    import lpm_pkg::*;

    typedef struct {
        pix_t px;
        pix_t py;
    } pix_item_t;

    typedef struct {
        dist_t dx;
        dist_t dy;
        logic  sat;
    } dist_item_t;
endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import lpm_pkg::*;
    import tb_lpm_types::*;

    localparam int PIPE_LAT  = 1 + DIV_N + 32;
    localparam int WDOG_LIM  = 20000;
    localparam int HOLD_LEN  = 400;

    // Index past the end of the register map
    localparam cfg_idx_t UNMAPPED_IDX = 4'd12;

    logic clk;
    logic rst_n;

    lpm_pix_if  pix ();
    lpm_dist_if dout ();
    lpm_cfg_if  cfg ();

    lens_distortion_point_map i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix.sink),
        .dout  (dout.source),
        .cfg   (cfg.sink)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Predictor copy of the register file
    logic [FOCAL_W-1:0]  m_focal_x, m_focal_y;
    logic [CENTRE_W-1:0] m_centre_x, m_centre_y;
    logic [COEF_W-1:0]   m_k1, m_k2, m_k3;
    logic [47:0]         m_tan;

    pix_item_t  pending_pix[$];
    dist_item_t expected_dist[$];
    bit         failed;
    bit         long_hold_req;
    int         wdog;

    // Saturation to +-QMAX on a 128-bit value
    function automatic longint clip_q(logic signed [127:0] v, ref bit sat);
        if (v > $signed({64'd0, QMAX}))
        begin
            sat = 1;
            return QMAX;
        end
        if (v < -$signed({64'd0, QMAX}))
        begin
            sat = 1;
            return -QMAX;
        end
        return v[63:0];
    endfunction

    function automatic longint add_q(longint a, longint b, ref bit sat);
        logic signed [127:0] s;
        s = 128'(signed'(a)) + 128'(signed'(b));
        return clip_q(s, sat);
    endfunction

    // Q.24 product, rounded half away from zero
    function automatic longint mul_q(longint a, longint b, ref bit sat);
        logic [127:0] ua, ub, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 128'(-a) : 128'(a);
        ub = b < 0 ? 128'(-b) : 128'(b);
        p = (ua * ub + (128'd1 << 23)) >> 24;
        if (p > 128'(QMAX))
        begin
            sat = 1;
            p = 128'(QMAX);
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint norm_coord(pix_t pv, logic [CENTRE_W-1:0] c,
                                          logic [FOCAL_W-1:0] f);
        longint d, fe;
        logic [127:0] mag, q;
        fe = f < FOCAL_MIN ? 256 : f;
        d = longint'({pv, {PIX_SH{1'b0}}}) - longint'(c);
        mag = d < 0 ? 128'(-d) : 128'(d);
        q = ((mag << 24) + 128'(fe / 2)) / 128'(fe);
        return d < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic dist_t back_to_pixel(longint v, logic [FOCAL_W-1:0] f,
                                            logic [CENTRE_W-1:0] c, ref bit sat);
        longint t, fe;
        logic [63:0] mag;
        fe = f < FOCAL_MIN ? 256 : f;
        t = mul_q(v, fe, sat);
        t = add_q(t, longint'(c), sat);
        mag = t < 0 ? -t : t;
        mag = (mag + ROUND_HALF) >> PIX_SH;
        t = t < 0 ? -longint'(mag) : longint'(mag);
        if (t > OUT_MAX)
        begin
            sat = 1;
            t = OUT_MAX;
        end
        if (t < OUT_MIN)
        begin
            sat = 1;
            t = OUT_MIN;
        end
        return t[OUT_W-1:0];
    endfunction

    // Distorted position of one pixel pair under the current registers
    function automatic dist_item_t distort_point(pix_item_t it);
        dist_item_t r;
        bit sat;
        longint k1, k2, k3, p1, p2, x, y, xx, yy, xy, r2, r4, r6, rad, xd, yd, t;
        sat = 0;
        k1 = longint'(signed'(m_k1));
        k2 = longint'(signed'(m_k2));
        k3 = longint'(signed'(m_k3));
        p1 = longint'(signed'(m_tan[23:0])) * 16;
        p2 = longint'(signed'(m_tan[47:24])) * 16;
        x = norm_coord(it.px, m_centre_x, m_focal_x);
        y = norm_coord(it.py, m_centre_y, m_focal_y);
        xx = mul_q(x, x, sat);
        yy = mul_q(y, y, sat);
        xy = mul_q(x, y, sat);
        r2 = add_q(xx, yy, sat);
        r4 = mul_q(r2, r2, sat);
        r6 = mul_q(r4, r2, sat);
        rad = add_q(Q_ONE, mul_q(k1, r2, sat), sat);
        rad = add_q(rad, mul_q(k2, r4, sat), sat);
        rad = add_q(rad, mul_q(k3, r6, sat), sat);
        t = mul_q(p1, xy, sat);
        xd = add_q(mul_q(x, rad, sat), add_q(t, t, sat), sat);
        xd = add_q(xd, mul_q(p2, add_q(r2, add_q(xx, xx, sat), sat), sat), sat);
        t = mul_q(p2, xy, sat);
        yd = add_q(mul_q(y, rad, sat),
                   mul_q(p1, add_q(r2, add_q(yy, yy, sat), sat), sat), sat);
        yd = add_q(yd, add_q(t, t, sat), sat);
        r.dx = back_to_pixel(xd, m_focal_x, m_centre_x, sat);
        r.dy = back_to_pixel(yd, m_focal_y, m_centre_y, sat);
        r.sat = sat;
        return r;
    endfunction

    // Driver: bursts and gaps on the pixel channel
    int burst_left, gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid   <= 1'b0;
            pix.pixel_x <= '0;
            pix.pixel_y <= '0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                expected_dist = {expected_dist, distort_point(pending_pix.pop_front())};
            end
            if (!pix.valid || pix.ready)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(30, 1);
                    gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    pix.valid <= 1'b0;
                end
                else if (pending_pix.size() > 0)
                begin
                    burst_left--;
                    pix.valid   <= 1'b1;
                    pix.pixel_x <= pending_pix[0].px;
                    pix.pixel_y <= pending_pix[0].py;
                end
                else
                begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off
    int stall_mode, hold_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout.ready <= 1'b0;
            hold_cnt   = 0;
        end
        else if (long_hold_req && hold_cnt == 0)
        begin
            hold_cnt = HOLD_LEN;
            long_hold_req = 0;
            dout.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            dout.ready <= (hold_cnt == 0);
        end
        else
        begin
            if ($urandom_range(63, 0) == 0)
                stall_mode = $urandom_range(2, 0);
            case (stall_mode)
                0: dout.ready <= 1'b1;
                1: dout.ready <= ($urandom_range(3, 0) != 0);
                default: dout.ready <= ($urandom_range(1, 0) == 0);
            endcase
        end
    end

    // Monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix.valid && pix.ready) || (dout.valid && dout.ready))
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_LIM)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (dout.valid && dout.ready)
            begin
                dist_item_t e;
                if (expected_dist.size() == 0)
                begin
                    $error("result with no expectation: dist_x %0d dist_y %0d",
                           dout.dist_x, dout.dist_y);
                    failed = 1;
                end
                else
                begin
                    e = expected_dist.pop_front();
                    if (dout.dist_x !== e.dx)
                    begin
                        $error("dist_x expected %0d actual %0d", e.dx, dout.dist_x);
                        failed = 1;
                    end
                    if (dout.dist_y !== e.dy)
                    begin
                        $error("dist_y expected %0d actual %0d", e.dy, dout.dist_y);
                        failed = 1;
                    end
                    if (dout.saturated !== e.sat)
                    begin
                        $error("saturated expected %0b actual %0b", e.sat, dout.saturated);
                        failed = 1;
                    end
                end
            end
        end
    end

    // One register write; the extra edge keeps back-to-back writes apart
    task automatic write_reg(cfg_reg_e idx, cfg_data_t val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_FOCAL_X:   m_focal_x  = val[FOCAL_W-1:0];
            REG_FOCAL_Y:   m_focal_y  = val[FOCAL_W-1:0];
            REG_CENTRE_X:  m_centre_x = val[CENTRE_W-1:0];
            REG_CENTRE_Y:  m_centre_y = val[CENTRE_W-1:0];
            REG_RADIAL_K1: m_k1 = val[COEF_W-1:0];
            REG_RADIAL_K2: m_k2 = val[COEF_W-1:0];
            REG_RADIAL_K3: m_k3 = val[COEF_W-1:0];
            REG_TANGENTIAL: m_tan = val[47:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Wait for the pipeline to drain before touching the registers
    task automatic drain_pipe();
        while (pending_pix.size() > 0 || pix.valid || expected_dist.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic queue_random(int n, bit near_centre);
        pix_item_t it;
        for (int i = 0; i < n; i++)
        begin
            if (near_centre && $urandom_range(4, 0) != 0)
            begin
                it.px = 16'((m_centre_x >> PIX_SH) + $urandom_range(2047, 0) - 1024);
                it.py = 16'((m_centre_y >> PIX_SH) + $urandom_range(2047, 0) - 1024);
            end
            else
            begin
                it.px = 16'($urandom);
                it.py = 16'($urandom);
            end
            pending_pix = {pending_pix, it};
        end
    endtask

    // Stimulus
    initial
    begin
        pix_item_t it;
        logic [23:0] p1, p2;
        failed = 0;
        long_hold_req = 0;
        wdog = 0;
        stall_mode = 0;
        m_focal_x = 24'd256; m_focal_y = 24'd256;
        m_centre_x = '0; m_centre_y = '0;
        m_k1 = '0; m_k2 = '0; m_k3 = '0; m_tan = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: identity map at the extremes
        for (int b = 0; b < PIX_W; b++)
        begin
            it.px = 16'd1 << b;
            it.py = ~(16'd1 << b);
            pending_pix = {pending_pix, it};
        end
        it.px = 16'h0000; it.py = 16'h0000; pending_pix = {pending_pix, it};
        it.px = 16'hFFFF; it.py = 16'hFFFF; pending_pix = {pending_pix, it};
        drain_pipe();

        // Directed: focal below one, big coefficients forcing internal overflow
        write_reg(REG_FOCAL_X, 0);
        write_reg(REG_FOCAL_Y, 255);
        write_reg(REG_CENTRE_X, 20'hFFFFF);
        write_reg(REG_CENTRE_Y, 20'h80000);
        write_reg(REG_RADIAL_K1, 48'h7FFFFFFF);
        write_reg(REG_RADIAL_K2, 48'h80000000);
        write_reg(REG_RADIAL_K3, 48'h7FFFFFFF);
        write_reg(REG_TANGENTIAL, 48'h7FFFFF_800000);
        cfg.valid <= 1'b1;
        cfg.index <= UNMAPPED_IDX;
        cfg.data  <= '1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        it.px = 16'h0000; it.py = 16'h0000; pending_pix = {pending_pix, it};
        it.px = 16'hFFFF; it.py = 16'hFFFF; pending_pix = {pending_pix, it};
        it.px = 16'h8000; it.py = 16'h8000; pending_pix = {pending_pix, it};
        it.px = 16'hFFF0; it.py = 16'h0001; pending_pix = {pending_pix, it};
        drain_pipe();

        // Random phases; the first two use extreme focal lengths, phase 4 requests the hold-off
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_FOCAL_X, (ph == 0) ? 24'hFFFFFF : $urandom_range(24'h40000, 0));
            write_reg(REG_FOCAL_Y, (ph == 1) ? 24'd256 : $urandom_range(24'h40000, 0));
            write_reg(REG_CENTRE_X, $urandom_range(20'hFFFFF, 0));
            write_reg(REG_CENTRE_Y, $urandom_range(20'hFFFFF, 0));
            write_reg(REG_RADIAL_K1, (ph % 3 == 0) ? $urandom : $urandom_range(1 << 24, 0) - (1 << 23));
            write_reg(REG_RADIAL_K2, (ph % 3 == 0) ? $urandom : $urandom_range(1 << 22, 0) - (1 << 21));
            write_reg(REG_RADIAL_K3, (ph % 3 == 0) ? $urandom : $urandom_range(1 << 20, 0) - (1 << 19));
            p1 = (ph % 3 == 0) ? 24'($urandom) : 24'($urandom_range(1 << 16, 0) - (1 << 15));
            p2 = (ph % 3 == 0) ? 24'($urandom) : 24'($urandom_range(1 << 16, 0) - (1 << 15));
            write_reg(REG_TANGENTIAL, {p2, p1});
            if (ph == 4)
                long_hold_req = 1;
            queue_random(150, ph % 3 != 0);
            drain_pipe();
        end

        if (failed)
            $display("SCOREBOARD MISMATCH");
        else
            $display("SCOREBOARD CLEAN");
        $finish;
    end
endmodule
